@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with a reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold on the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/shbi_pkg.sv @@
// ----------------------------------------------------------------------------
// shbi_pkg
// Widths, types and constants of the string hash bucket index block.
// ----------------------------------------------------------------------------
package shbi_pkg;

   localparam int CHAR_W   = 8;
   localparam int WEIGHT_W = 32;
   localparam int SUM_W    = 64;
   localparam int TS_W     = 31;
   localparam int CNT_W    = $clog2(SUM_W);

   typedef logic signed [CHAR_W-1:0] char_type;
   typedef logic [WEIGHT_W-1:0]      weight_type;
   typedef logic [SUM_W-1:0]         sum_type;
   typedef logic [TS_W-1:0]          bucket_type;
   typedef logic [CNT_W-1:0]         cnt_type;

   localparam weight_type WEIGHT_START = weight_type'(26);
   localparam weight_type WEIGHT_MUL   = weight_type'(43);
   localparam bucket_type TS_RESET     = bucket_type'(101);

endpackage

@@ rtl/shbi_req_if.sv @@
// ----------------------------------------------------------------------------
// shbi_req_if
// Request channel: one character of a string per transaction.
// ----------------------------------------------------------------------------
interface shbi_req_if import shbi_pkg::*; ();

   logic     valid;
   logic     ready;
   char_type character;
   logic     last_char;

   modport source (output valid, output character, output last_char, input ready);
   modport sink   (input valid, input character, input last_char, output ready);

endinterface

@@ rtl/shbi_rsp_if.sv @@
// ----------------------------------------------------------------------------
// shbi_rsp_if
// Response channel: one bucket index per completed string.
// ----------------------------------------------------------------------------
interface shbi_rsp_if import shbi_pkg::*; ();

   logic       valid;
   logic       ready;
   bucket_type bucket;

   modport source (output valid, output bucket, input ready);
   modport sink   (input valid, input bucket, output ready);

endinterface

@@ rtl/string_hash_bucket_index.sv @@
// ----------------------------------------------------------------------------
// string_hash_bucket_index
// Polynomial string hash reduced to a bucket index by a bit-serial divider.
// ----------------------------------------------------------------------------
// Usage:
// A string enters on req_ch one signed character per transaction, its final
// character marked by last_char. Within a string a character is accepted in
// every cycle. Each character is multiplied by the running weight and the
// wrapped product is added into a 64-bit sum in the cycle after.
// After the final character the sum's magnitude is taken in ST_NEG and
// reduced modulo table_size by a restoring divider that consumes one
// dividend bit per cycle. ST_FIX registers the bucket on rsp_ch once any
// previous bucket has been taken; the next string is accepted only after
// that. table_size is to be written through csr_we/csr_wdata only while
// the block is idle; the block itself does not enforce this.
// Reset sets table_size to 101, clears the sum and reloads the weight.
// While a bucket waits on rsp_ch, characters of the next string are still
// accepted; only the next bucket waits until the previous one is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module string_hash_bucket_index import shbi_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   shbi_req_if.sink        req_ch,
   shbi_rsp_if.source      rsp_ch,
   input  logic            csr_we,
   input  logic [TS_W-1:0] csr_wdata
);

   localparam logic [1:0] ST_ACC = 2'd0;
   localparam logic [1:0] ST_NEG = 2'd1;
   localparam logic [1:0] ST_DIV = 2'd2;
   localparam logic [1:0] ST_FIX = 2'd3;

   logic [1:0]  state_ff, state_in;
   bucket_type  ts_ff;
   weight_type  weight_ff, weight_in;
   sum_type     sum_ff, sum_in;
   weight_type  prod_ff;
   logic        pvalid_ff, plast_ff;
   sum_type     dvd_ff, dvd_in;
   bucket_type  rem_ff, rem_in;
   logic        sign_ff, sign_in;
   cnt_type     cnt_ff, cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   bucket_type  rsp_bucket_ff, rsp_bucket_in;

   logic        req_go;
   logic        fix_go;
   logic [TS_W:0]   trial;
   logic [TS_W+1:0] diff;

   assign req_ch.ready = (state_ff == ST_ACC) && !(pvalid_ff && plast_ff);
   assign req_go       = req_ch.valid && req_ch.ready;
   assign fix_go       = (state_ff == ST_FIX) && (!rsp_valid_ff || rsp_ch.ready);

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.bucket = rsp_bucket_ff;

   // One restoring division step: shift in the next dividend bit and try
   // to subtract the table size.
   assign trial = {rem_ff, dvd_ff[SUM_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, ts_ff};

   always_comb begin
      state_in      = state_ff;
      weight_in     = weight_ff;
      sum_in        = sum_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      sign_in       = sign_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_bucket_in = rsp_bucket_ff;

      if (req_go) begin
         weight_in = req_ch.last_char ? WEIGHT_START : weight_type'(weight_ff * WEIGHT_MUL);
      end

      if (pvalid_ff) begin
         sum_in = sum_ff + {{(SUM_W-WEIGHT_W){prod_ff[WEIGHT_W-1]}}, prod_ff};
      end

      case (state_ff)
         ST_ACC: begin
            if (pvalid_ff && plast_ff) begin
               state_in = ST_NEG;
            end
         end
         ST_NEG: begin
            sign_in  = sum_ff[SUM_W-1];
            dvd_in   = sum_ff[SUM_W-1] ? (sum_type'(0) - sum_ff) : sum_ff;
            sum_in   = '0;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = diff[TS_W+1] ? trial[TS_W-1:0] : diff[TS_W-1:0];
            dvd_in = {dvd_ff[SUM_W-2:0], 1'b0};
            cnt_in = cnt_ff + cnt_type'(1);
            if (cnt_ff == cnt_type'(SUM_W-1)) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            if (fix_go) begin
               rsp_valid_in = 1'b1;
               if (ts_ff == '0) begin
                  rsp_bucket_in = '0;
               end else if (sign_ff && (rem_ff != '0)) begin
                  rsp_bucket_in = ts_ff - rem_ff;
               end else begin
                  rsp_bucket_in = rem_ff;
               end
               state_in = ST_ACC;
            end
         end
         default: begin
            state_in = ST_ACC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACC;
         ts_ff        <= TS_RESET;
         weight_ff    <= WEIGHT_START;
         sum_ff       <= '0;
         pvalid_ff    <= 1'b0;
         plast_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         weight_ff    <= weight_in;
         sum_ff       <= sum_in;
         pvalid_ff    <= req_go;
         plast_ff     <= req_go && req_ch.last_char;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            ts_ff <= csr_wdata;
         end
      end
   end

   // Product of the weight and the sign-extended character, wrapped at 32 bits.
   always_ff @(posedge clock) begin
      if (req_go) begin
         prod_ff <= weight_type'(weight_ff *
                    {{(WEIGHT_W-CHAR_W){req_ch.character[CHAR_W-1]}}, req_ch.character});
      end
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      sign_ff       <= sign_in;
      cnt_ff        <= cnt_in;
      rsp_bucket_ff <= rsp_bucket_in;
   end

   `ASSERT_CLK(a_accept_only_acc, clock, reset, !req_go || (state_ff == ST_ACC), "character accepted outside accumulation")
   `ASSERT_NEXT(a_div_runs, clock, reset, (state_ff == ST_DIV) && (cnt_ff != cnt_type'(SUM_W-1)), state_ff == ST_DIV, "division left early")
   `ASSERT_NEXT(a_fix_emits, clock, reset, fix_go, rsp_valid_ff && (state_ff == ST_ACC), "bucket not presented after division")

endmodule

@@ tb/string_hash_bucket_index_tb.sv @@
// ----------------------------------------------------------------------------
// string_hash_bucket_index_tb
// Self-checking bench: strings go in one character per transaction, and each
// bucket index that comes back is compared with a bit-accurate hash predictor.
// A directed table covers reset defaults, character extremes, table-size
// extremes and negative sums; random strings under several table sizes follow.
// ----------------------------------------------------------------------------
module string_hash_bucket_index_tb import shbi_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_ITEMS = 700;
   localparam int unsigned PHASE_ITEMS  = 100;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned TAIL_CYCLES  = 80;
   localparam int unsigned MAX_REPORTS  = 10;

   typedef enum logic {ROW_CHAR, ROW_TABLE_SIZE} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      char_type     ch;
      logic         last;
      bucket_type   value;    // table size for ROW_TABLE_SIZE rows
      logic         has_lit;
      bucket_type   lit;
   } dir_row_type;

   // Negative characters are written in hex: 8'h80 is -128, 8'hFF is -1,
   // 8'hA6 is -90 and 8'hF9 is -7.
   localparam dir_row_type DIRECTED [28] = '{
      '{ROW_CHAR,       8'd97,  1'b1, 31'd0,          1'b1, 31'd98},
      '{ROW_CHAR,       8'h7F,  1'b1, 31'd0,          1'b1, 31'd70},
      '{ROW_CHAR,       8'h80,  1'b1, 31'd0,          1'b1, 31'd5},
      '{ROW_CHAR,       8'hFF,  1'b1, 31'd0,          1'b1, 31'd75},
      '{ROW_CHAR,       8'd0,   1'b1, 31'd0,          1'b1, 31'd0},
      '{ROW_CHAR,       8'd104, 1'b0, 31'd0,          1'b0, 31'd0},
      '{ROW_CHAR,       8'd97,  1'b0, 31'd0,          1'b0, 31'd0},
      '{ROW_CHAR,       8'd115, 1'b0, 31'd0,          1'b0, 31'd0},
      '{ROW_CHAR,       8'd104, 1'b1, 31'd0,          1'b0, 31'd0},
      '{ROW_TABLE_SIZE, 8'd0,   1'b0, 31'd13,         1'b0, 31'd0},
      '{ROW_CHAR,       8'hFF,  1'b1, 31'd0,          1'b1, 31'd0},
      '{ROW_TABLE_SIZE, 8'd0,   1'b0, 31'd1,          1'b0, 31'd0},
      '{ROW_CHAR,       8'd55,  1'b0, 31'd0,          1'b0, 31'd0},
      '{ROW_CHAR,       8'hA6,  1'b1, 31'd0,          1'b1, 31'd0},
      '{ROW_TABLE_SIZE, 8'd0,   1'b0, 31'd0,          1'b0, 31'd0},
      '{ROW_CHAR,       8'd100, 1'b1, 31'd0,          1'b1, 31'd0},
      '{ROW_CHAR,       8'hF9,  1'b1, 31'd0,          1'b1, 31'd0},
      '{ROW_TABLE_SIZE, 8'd0,   1'b0, 31'h7FFFFFFF,   1'b0, 31'd0},
      '{ROW_CHAR,       8'h80,  1'b1, 31'd0,          1'b1, 31'd2147480319},
      '{ROW_CHAR,       8'h7F,  1'b1, 31'd0,          1'b1, 31'd3302},
      '{ROW_CHAR,       8'h80,  1'b0, 31'd0,          1'b0, 31'd0},
      '{ROW_CHAR,       8'h7F,  1'b0, 31'd0,          1'b0, 31'd0},
      '{ROW_CHAR,       8'h80,  1'b0, 31'd0,          1'b0, 31'd0},
      '{ROW_CHAR,       8'h7F,  1'b0, 31'd0,          1'b0, 31'd0},
      '{ROW_CHAR,       8'h80,  1'b0, 31'd0,          1'b0, 31'd0},
      '{ROW_CHAR,       8'h7F,  1'b0, 31'd0,          1'b0, 31'd0},
      '{ROW_CHAR,       8'h80,  1'b0, 31'd0,          1'b0, 31'd0},
      '{ROW_CHAR,       8'h7F,  1'b1, 31'd0,          1'b0, 31'd0}
   };

   logic            clock;
   logic            reset;
   logic            csr_we;
   logic [TS_W-1:0] csr_wdata;

   shbi_req_if req_ch();
   shbi_rsp_if rsp_ch();

   string_hash_bucket_index i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Predictor state.
   sum_type     hash_sum;
   weight_type  hash_weight;
   bucket_type  table_size_now;
   bucket_type  bucket_queue[$];

   int unsigned error_count;
   int unsigned items_sent;
   int unsigned stall_left;
   bit          source_steady;
   bit          sink_steady;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAIL string_hash_bucket_index");
      $finish;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic void note_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("%0t: %s", $realtime, msg);
      end
   endfunction

   // Offers one character, waits for its transaction and updates the predictor.
   task automatic send_char(input char_type ch, input logic last,
                            input logic has_lit, input bucket_type lit);
      int unsigned idle;
      weight_type  prod;
      sum_type     mag;
      sum_type     rem;
      bucket_type  want;
      idle = source_steady ? 0 : pick_gap();
      if (idle != 0) begin
         req_ch.valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.character <= ch;
      req_ch.last_char <= last;
      do @(posedge clock); while (req_ch.ready !== 1'b1);

      prod        = hash_weight * {{24{ch[7]}}, ch};
      hash_sum    = hash_sum + {{32{prod[31]}}, prod};
      hash_weight = hash_weight * WEIGHT_MUL;
      items_sent++;
      if (last) begin
         // Truncating signed remainder, folded into the range of the table.
         mag = hash_sum[63] ? -hash_sum : hash_sum;
         if (table_size_now == '0) begin
            want = '0;
         end else begin
            rem  = mag % sum_type'(table_size_now);
            want = (hash_sum[63] && rem != '0) ? table_size_now - bucket_type'(rem)
                                                : bucket_type'(rem);
         end
         bucket_queue.push_back(has_lit ? lit : want);
         hash_sum    = '0;
         hash_weight = WEIGHT_START;
      end
   endtask

   // The table size is only changed once every string has been answered.
   task automatic set_table_size(input bucket_type ts);
      req_ch.valid <= 1'b0;
      while (bucket_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= ts;
      @(posedge clock);
      csr_we <= 1'b0;
      table_size_now = ts;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (!sink_steady && $urandom_range(0, 2) == 0) begin
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (bucket_queue.size() == 0) begin
            note_mismatch($sformatf("unexpected bucket %0d", rsp_ch.bucket));
         end else if (rsp_ch.bucket !== bucket_queue[0]) begin
            note_mismatch($sformatf("bucket expected %0d, got %0d",
                                    bucket_queue[0], rsp_ch.bucket));
            void'(bucket_queue.pop_front());
         end else begin
            void'(bucket_queue.pop_front());
         end
      end
   end

   initial begin
      int unsigned phase;
      int unsigned phase_start;
      int unsigned len;
      int unsigned target;
      bucket_type  ts;
      char_type    ch;

      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_wdata        <= '0;
      req_ch.valid     <= 1'b0;
      req_ch.character <= '0;
      req_ch.last_char <= 1'b0;
      hash_sum       = '0;
      hash_weight    = WEIGHT_START;
      table_size_now = TS_RESET;
      error_count    = 0;
      items_sent     = 0;
      source_steady  = 1'b0;
      sink_steady    = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].kind == ROW_TABLE_SIZE) begin
            set_table_size(DIRECTED[i].value);
         end else begin
            send_char(DIRECTED[i].ch, DIRECTED[i].last, DIRECTED[i].has_lit,
                      DIRECTED[i].lit);
         end
      end

      target = items_sent + RANDOM_ITEMS;
      phase  = 0;
      while (items_sent < target) begin
         case (phase % 7)
            0: ts = TS_RESET;
            1: ts = 31'd1;
            2: ts = '1;
            3: ts = bucket_type'($urandom_range(2, 64));
            4: ts = bucket_type'($urandom);
            5: ts = '0;
            default: ts = bucket_type'($urandom_range(65, 100000));
         endcase
         set_table_size(ts);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS && items_sent < target) begin
            case ($urandom_range(0, 9))
               0:       len = 1;
               7, 8:    len = $urandom_range(9, 16);
               9:       len = $urandom_range(20, 40);
               default: len = $urandom_range(2, 8);
            endcase
            source_steady = ($urandom_range(0, 4) == 0);
            sink_steady   = ($urandom_range(0, 4) == 0);
            for (int unsigned k = 0; k < len; k++) begin
               case ($urandom_range(0, 9))
                  0:       ch = $urandom_range(0, 1) ? 8'h7F : 8'h80;
                  5, 6:    ch = char_type'($urandom);
                  7:       ch = char_type'($urandom_range(0, 6) - 3);
                  8, 9:    ch = char_type'($urandom_range(32, 126));
                  default: ch = char_type'($urandom_range(97, 122));
               endcase
               send_char(ch, k == len - 1, 1'b0, '0);
            end
         end
         phase++;
      end

      req_ch.valid <= 1'b0;
      while (bucket_queue.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS string_hash_bucket_index");
      end else begin
         $display("FAIL string_hash_bucket_index");
      end
      $finish;
   end

endmodule
